[rtl/uer_pkg.sv]
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; the sequencer, scaler, top level and bench import this package.
package uer_pkg;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TLOW  = 3'd1,
    PH_THIGH = 3'd2,
    PH_RISE  = 3'd3,
    PH_ECHO  = 3'd4,
    PH_GAP   = 3'd5
  } phase_t;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_TRIG_LOW  = 3'd0,
    REG_TRIG_HIGH = 3'd1,
    REG_RISE_TO   = 3'd2,
    REG_ECHO_TO   = 3'd3,
    REG_GAP       = 3'd4,
    REG_AVG_EN    = 3'd5
  } reg_idx_t;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [9:0]  TRIG_LOW_RST  = 10'd10;
  localparam logic [9:0]  TRIG_HIGH_RST = 10'd20;
  localparam logic [15:0] RISE_TO_RST   = 16'd5000;
  localparam logic [15:0] ECHO_TO_RST   = 16'd20000;
  localparam logic [15:0] GAP_RST       = 16'd10000;

  // Microseconds of round trip per centimeter
  localparam int unsigned US_PER_CM = 58;

  localparam int unsigned WIDTH_W = 16;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned DIST_W  = 15;

  typedef struct packed {
    logic [9:0]  trigger_low_us;
    logic [9:0]  trigger_high_us;
    logic [15:0] rise_timeout_us;
    logic [15:0] echo_timeout_us;
    logic [15:0] reading_gap_us;
    logic        average_enable;
  } cfg_t;

  // One tick's outcome from the sequencer, before scaling
  typedef struct packed {
    logic             trig;
    logic             busy;
    logic             done;
    logic             tout;
    logic             avg;    // numerator is a sum of readings
    logic [SUM_W-1:0] num;    // zero unless a good result
  } seq_res_t;

endpackage

[rtl/uer_if.sv]
// Valid/ready channel interfaces for the ranger's tick input and result output.
// Depends on nothing.
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_request;
  logic echo_level;

  modport source (output valid, start_request, echo_level, input ready);
  modport sink (input valid, start_request, echo_level, output ready);
endinterface

interface uer_out_if;
  logic        valid;
  logic        ready;
  logic        trigger_level;
  logic        busy_res;
  logic        result_valid;
  logic [14:0] distance_sixteenths;
  logic        timed_out;

  modport source (output valid, trigger_level, busy_res, result_valid,
                  distance_sixteenths, timed_out, input ready);
  modport sink (input valid, trigger_level, busy_res, result_valid,
                distance_sixteenths, timed_out, output ready);
endinterface

[rtl/uer_seq.sv]
// Measurement sequencer: trigger, rise wait, echo count, gap, averaging sum.
// Depends on uer_pkg. State advances once per accepted tick word.
module uer_seq #(
  parameter int unsigned READINGS = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             start_request,
  input  logic             echo_level,
  input  uer_pkg::cfg_t    cfg,
  output uer_pkg::seq_res_t res
);
  import uer_pkg::*;

  localparam logic [COUNT_W-1:0] READ_N = COUNT_W'(READINGS);

  phase_t             phase, phase_next;
  logic [15:0]        timer, timer_next;
  logic [WIDTH_W-1:0] width, width_next;
  logic [SUM_W-1:0]   sum, sum_next;
  logic [COUNT_W-1:0] rdone, rdone_next;

  logic [15:0]        t1;
  logic [WIDTH_W-1:0] w1;
  logic [SUM_W-1:0]   sum1;
  logic [COUNT_W-1:0] rd1;
  logic               timeout, rend;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      timer <= '0;
      width <= '0;
      sum   <= '0;
      rdone <= '0;
    end else if (step) begin
      phase <= phase_next;
      timer <= timer_next;
      width <= width_next;
      sum   <= sum_next;
      rdone <= rdone_next;
    end
  end

  always_comb begin
    t1   = timer + 16'd1;
    w1   = width + WIDTH_W'(1);
    sum1 = sum + SUM_W'(width);
    rd1  = rdone + COUNT_W'(1);

    phase_next = phase;
    timer_next = timer;
    width_next = width;
    sum_next   = sum;
    rdone_next = rdone;
    timeout    = 1'b0;
    rend       = 1'b0;
    res        = '0;

    case (phase)
      PH_TLOW: begin
        timer_next = t1;
        if (t1 >= {6'd0, cfg.trigger_low_us}) begin
          phase_next = PH_THIGH;
          timer_next = '0;
        end
      end
      PH_THIGH: begin
        res.trig   = 1'b1;
        timer_next = t1;
        if (t1 >= {6'd0, cfg.trigger_high_us}) begin
          phase_next = PH_RISE;
          timer_next = '0;
        end
      end
      PH_RISE: begin
        if (echo_level) begin
          width_next = WIDTH_W'(1);
          phase_next = PH_ECHO;
          timer_next = '0;
          // a timeout limit of 0 or 1 trips on the first echo tick
          if (cfg.echo_timeout_us <= 16'd1) timeout = 1'b1;
        end else begin
          timer_next = t1;
          if (t1 >= cfg.rise_timeout_us) timeout = 1'b1;
        end
      end
      PH_ECHO: begin
        if (echo_level) begin
          width_next = w1;
          if (w1 >= cfg.echo_timeout_us) timeout = 1'b1;
        end else begin
          rend = 1'b1;
        end
      end
      PH_GAP: begin
        timer_next = t1;
        if (t1 >= cfg.reading_gap_us) begin
          phase_next = PH_TLOW;
          timer_next = '0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (start_request) begin
          phase_next = PH_TLOW;
          timer_next = '0;
          width_next = '0;
          sum_next   = '0;
          rdone_next = '0;
        end
      end
    endcase

    if (timeout) begin
      res.done   = 1'b1;
      res.tout   = 1'b1;
      phase_next = PH_IDLE;
      timer_next = '0;
      sum_next   = '0;
      rdone_next = '0;
    end else if (rend) begin
      timer_next = '0;
      if (!cfg.average_enable) begin
        res.done   = 1'b1;
        res.num    = SUM_W'(width);
        phase_next = PH_IDLE;
        sum_next   = '0;
        rdone_next = '0;
      end else if (rd1 >= READ_N) begin
        res.done   = 1'b1;
        res.avg    = 1'b1;
        res.num    = sum1;
        phase_next = PH_IDLE;
        sum_next   = '0;
        rdone_next = '0;
      end else begin
        sum_next   = sum1;
        rdone_next = rd1;
        phase_next = PH_GAP;
      end
    end

    res.busy = (phase_next != PH_IDLE);
  end

endmodule

[rtl/uer_scale.sv]
// Converts echo microseconds (or a sum of readings) to 1/16 cm.
// Depends on uer_pkg. Exact floor division by reciprocal multiplication.
module uer_scale #(
  parameter int unsigned READINGS = 5
) (
  input  logic [uer_pkg::SUM_W-1:0]  num,
  input  logic                       avg,
  output logic [uer_pkg::DIST_W-1:0] sixteenths
);
  import uer_pkg::*;

  // n = num * 16 < 2^24 and divisor < 2^10, so a 34-bit shift keeps the
  // rounded-up reciprocal exact for every numerator
  localparam int unsigned NUM_W   = SUM_W + 4;
  localparam int unsigned SHIFT   = 34;
  localparam int unsigned RECIP_W = 29;
  localparam longint unsigned DIV_ONE = US_PER_CM;
  localparam longint unsigned DIV_AVG = US_PER_CM * READINGS;
  localparam logic [RECIP_W-1:0] RECIP_ONE =
    RECIP_W'(((64'd1 << SHIFT) + DIV_ONE - 1) / DIV_ONE);
  localparam logic [RECIP_W-1:0] RECIP_AVG =
    RECIP_W'(((64'd1 << SHIFT) + DIV_AVG - 1) / DIV_AVG);
  localparam int unsigned PROD_W = NUM_W + RECIP_W;
  localparam int unsigned QUOT_W = PROD_W - SHIFT;
  localparam logic [QUOT_W-1:0] DIST_MAX = QUOT_W'({DIST_W{1'b1}});

  logic [NUM_W-1:0]   numer;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;
  logic [QUOT_W-1:0]  quot;

  always_comb begin
    numer      = {num, 4'b0000};
    recip      = avg ? RECIP_AVG : RECIP_ONE;
    prod       = PROD_W'(numer) * PROD_W'(recip);
    quot       = prod[PROD_W-1:SHIFT];
    sixteenths = (quot > DIST_MAX) ? DIST_W'(DIST_MAX) : quot[DIST_W-1:0];
  end

endmodule

[rtl/ultrasonic_echo_ranger.sv]
// Ultrasonic echo-pulse ranger top level: APB registers and result pipeline.
// Depends on uer_pkg, uer_if, uer_seq and uer_scale.
//
// Each word on req is one microsecond tick (start request and sampled echo
// level) and yields exactly one word on rsp: trigger level, busy flag, and
// on the finishing tick the result flag, distance in 1/16 cm and timeout
// flag. One word is taken per clock unless rsp back-pressure stalls it; the
// sequencer state updates in the accept cycle, a stage register holds its
// outcome, and the reciprocal multiplier that scales the distance feeds the
// output register on rsp. Configuration is written over APB (register i at
// byte address 4*i), by the user only while the block idles (not enforced).
module ultrasonic_echo_ranger #(
  parameter int unsigned READINGS = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  uer_in_if.sink                       req,
  uer_out_if.source                    rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [uer_pkg::ADDR_W-1:0]   paddr,
  input  logic [uer_pkg::DATA_W-1:0]   pwdata,
  output logic [uer_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import uer_pkg::*;

  cfg_t     cfg;
  reg_idx_t widx;
  logic     wr_en;

  seq_res_t seq_res;
  logic     a_valid, b_valid;
  seq_res_t a_res;
  logic     a_ready, b_ready, step;
  logic [DIST_W-1:0] sixteenths;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_low_us  <= TRIG_LOW_RST;
      cfg.trigger_high_us <= TRIG_HIGH_RST;
      cfg.rise_timeout_us <= RISE_TO_RST;
      cfg.echo_timeout_us <= ECHO_TO_RST;
      cfg.reading_gap_us  <= GAP_RST;
      cfg.average_enable  <= 1'b0;
    end else if (wr_en) begin
      case (widx)
        REG_TRIG_LOW:  cfg.trigger_low_us  <= pwdata[9:0];
        REG_TRIG_HIGH: cfg.trigger_high_us <= pwdata[9:0];
        REG_RISE_TO:   cfg.rise_timeout_us <= pwdata[15:0];
        REG_ECHO_TO:   cfg.echo_timeout_us <= pwdata[15:0];
        REG_GAP:       cfg.reading_gap_us  <= pwdata[15:0];
        REG_AVG_EN:    cfg.average_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_TRIG_LOW:  prdata = DATA_W'(cfg.trigger_low_us);
      REG_TRIG_HIGH: prdata = DATA_W'(cfg.trigger_high_us);
      REG_RISE_TO:   prdata = DATA_W'(cfg.rise_timeout_us);
      REG_ECHO_TO:   prdata = DATA_W'(cfg.echo_timeout_us);
      REG_GAP:       prdata = DATA_W'(cfg.reading_gap_us);
      REG_AVG_EN:    prdata = DATA_W'(cfg.average_enable);
      default:       prdata = '0;
    endcase
  end

  // ---------------- pipeline ----------------
  assign b_ready   = !b_valid || rsp.ready;
  assign a_ready   = !a_valid || b_ready;
  assign req.ready = a_ready;
  assign step      = req.valid && a_ready;

  uer_seq #(.READINGS(READINGS)) u_seq (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .start_request (req.start_request),
    .echo_level    (req.echo_level),
    .cfg           (cfg),
    .res           (seq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      a_res <= seq_res;
    end
  end

  uer_scale #(.READINGS(READINGS)) u_scale (
    .num        (a_res.num),
    .avg        (a_res.avg),
    .sixteenths (sixteenths)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      rsp.trigger_level       <= a_res.trig;
      rsp.busy_res            <= a_res.busy;
      rsp.result_valid        <= a_res.done;
      rsp.timed_out           <= a_res.tout;
      rsp.distance_sixteenths <= sixteenths;
    end
  end

  assign rsp.valid = b_valid;

endmodule

[rtl/uer_chk.sv]
// Port-level checker for the ultrasonic echo ranger, bound to the top level.
// Depends on nothing but the top level's port names.
module uer_chk (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        trigger_level,
  input logic        busy_res,
  input logic        result_valid,
  input logic [14:0] distance_sixteenths,
  input logic        timed_out
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(distance_sixteenths)
      && $stable(result_valid) && $stable(timed_out))
    else $error("result word changed while stalled");

  a_dist_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (distance_sixteenths != 15'd0) |-> result_valid && !timed_out)
    else $error("distance without a good result");

  a_tout_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && timed_out |-> result_valid)
    else $error("timeout flag without result flag");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && result_valid |-> !busy_res && !trigger_level)
    else $error("finishing word still busy");

  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && trigger_level |-> busy_res)
    else $error("trigger driven while idle");

endmodule

bind ultrasonic_echo_ranger uer_chk u_chk (
  .clk                 (clk),
  .rst                 (rst),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .trigger_level       (rsp.trigger_level),
  .busy_res            (rsp.busy_res),
  .result_valid        (rsp.result_valid),
  .distance_sixteenths (rsp.distance_sixteenths),
  .timed_out           (rsp.timed_out)
);

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for ultrasonic_echo_ranger: feeds microsecond ticks, predicts each
// output word in a tracker class and compares field by field. Needs uer_pkg, uer_if, RTL.
module tb;
  import uer_pkg::*;

  localparam int unsigned READ_SET = 5;
  localparam logic [2:0] SPARE_REG = 3'd6;  // decodes to no register
  localparam int unsigned PRINT_CAP = 30;
  localparam int unsigned ITEM_GOAL = 1900;

  typedef struct packed {
    logic        trig;
    logic        busy;
    logic        done;
    logic [14:0] distance;
    logic        tout;
  } range_word_t;

  // Tracks the ranger's sequencer and registers, queues the word due for each tick
  class ranging_tracker;
    cfg_t        cfg;
    phase_t      seq_phase;
    logic [15:0] ticks_in_phase;
    logic [15:0] echo_ticks;
    logic [19:0] echo_sum;
    logic [3:0]  readings_taken;
    range_word_t due_words[$];
    bit          set_done;
    int unsigned ticks, sets, timeouts, averaged, words_seen, errors;

    function new();
      cfg.trigger_low_us  = TRIG_LOW_RST;
      cfg.trigger_high_us = TRIG_HIGH_RST;
      cfg.rise_timeout_us = RISE_TO_RST;
      cfg.echo_timeout_us = ECHO_TO_RST;
      cfg.reading_gap_us  = GAP_RST;
      cfg.average_enable  = 1'b0;
      seq_phase = PH_IDLE;
      ticks_in_phase = '0;
      echo_ticks = '0;
      echo_sum = '0;
      readings_taken = '0;
    endfunction

    function void report_mismatch(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_TRIG_LOW:  cfg.trigger_low_us = value[9:0];
        REG_TRIG_HIGH: cfg.trigger_high_us = value[9:0];
        REG_RISE_TO:   cfg.rise_timeout_us = value[15:0];
        REG_ECHO_TO:   cfg.echo_timeout_us = value[15:0];
        REG_GAP:       cfg.reading_gap_us = value[15:0];
        REG_AVG_EN:    cfg.average_enable = value[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_TRIG_LOW:  return {22'd0, cfg.trigger_low_us};
        REG_TRIG_HIGH: return {22'd0, cfg.trigger_high_us};
        REG_RISE_TO:   return {16'd0, cfg.rise_timeout_us};
        REG_ECHO_TO:   return {16'd0, cfg.echo_timeout_us};
        REG_GAP:       return {16'd0, cfg.reading_gap_us};
        REG_AVG_EN:    return {31'd0, cfg.average_enable};
        default:       return '0;
      endcase
    endfunction

    function void enter(phase_t p);
      seq_phase = p;
      ticks_in_phase = '0;
    endfunction

    // a zero limit still costs one tick
    function bit advance(logic [15:0] limit);
      ticks_in_phase++;
      return ticks_in_phase >= limit;
    endfunction

    function logic [14:0] to_sixteenths(logic [19:0] num, int unsigned div);
      longint unsigned q;
      q = num;
      q = q * 16 / div;
      return (q > 32767) ? 15'h7FFF : q[14:0];
    endfunction

    function void note_tick(logic start, logic echo);
      range_word_t w;
      bit reading_end, tout;
      w = '0;
      reading_end = 1'b0;
      tout = 1'b0;
      ticks++;
      case (seq_phase)
        PH_TLOW:
          if (advance({6'd0, cfg.trigger_low_us})) enter(PH_THIGH);
        PH_THIGH: begin
          w.trig = 1'b1;
          if (advance({6'd0, cfg.trigger_high_us})) enter(PH_RISE);
        end
        PH_RISE:
          if (echo) begin
            echo_ticks = 16'd1;
            enter(PH_ECHO);
            tout = (echo_ticks >= cfg.echo_timeout_us);
          end else begin
            tout = advance(cfg.rise_timeout_us);
          end
        PH_ECHO:
          if (echo) begin
            echo_ticks++;
            tout = (echo_ticks >= cfg.echo_timeout_us);
          end else begin
            reading_end = 1'b1;
          end
        PH_GAP:
          if (advance(cfg.reading_gap_us)) enter(PH_TLOW);
        default: begin
          seq_phase = PH_IDLE;
          if (start) begin
            enter(PH_TLOW);
            echo_ticks = '0;
            echo_sum = '0;
            readings_taken = '0;
          end
        end
      endcase

      if (tout) begin
        w.done = 1'b1;
        w.tout = 1'b1;
        enter(PH_IDLE);
        echo_sum = '0;
        readings_taken = '0;
        timeouts++;
      end else if (reading_end) begin
        // averaging is sampled as each reading ends
        if (!cfg.average_enable) begin
          w.done = 1'b1;
          w.distance = to_sixteenths(20'(echo_ticks), US_PER_CM);
          enter(PH_IDLE);
          echo_sum = '0;
          readings_taken = '0;
        end else begin
          echo_sum = echo_sum + 20'(echo_ticks);
          readings_taken++;
          if (readings_taken >= READ_SET) begin
            w.done = 1'b1;
            w.distance = to_sixteenths(echo_sum, US_PER_CM * READ_SET);
            enter(PH_IDLE);
            echo_sum = '0;
            readings_taken = '0;
            averaged++;
          end else begin
            enter(PH_GAP);
          end
        end
      end

      w.busy = (seq_phase != PH_IDLE);
      set_done = w.done;
      if (w.done) sets++;
      due_words.push_back(w);
    endfunction

    function void compare_field(string name, logic [14:0] got, logic [14:0] want);
      if (got !== want)
        report_mismatch($sformatf("word %0d %s: got %0d, expected %0d",
                                  words_seen, name, got, want));
    endfunction

    function void check_word(range_word_t got);
      range_word_t want;
      words_seen++;
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
        return;
      end
      want = due_words.pop_front();
      compare_field("trigger_level", got.trig, want.trig);
      compare_field("busy_res", got.busy, want.busy);
      compare_field("result_valid", got.done, want.done);
      compare_field("distance_sixteenths", got.distance, want.distance);
      compare_field("timed_out", got.tout, want.tout);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic              pready;

  uer_in_if  tick_ch();
  uer_out_if word_ch();

  ultrasonic_echo_ranger #(.READINGS(READ_SET)) dut (
    .clk     (clk),
    .rst     (rst),
    .req     (tick_ch),
    .rsp     (word_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ranging_tracker trk = new();

  // echo shaping for the next reading
  bit          fixed_plan, noisy, planned;
  int unsigned rise_at, echo_len;
  bit          send_idle, take_idle, long_hold;
  int unsigned cfg_writes;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
  endfunction

  task automatic send_tick();
    logic        start, echo;
    int unsigned pause;
    pause = (send_idle && $urandom_range(0, 5) == 0) ? gap_len() : 0;
    if (pause != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    if (trk.seq_phase != PH_RISE && trk.seq_phase != PH_ECHO) planned = 1'b0;
    start = 1'($urandom_range(0, 1));
    echo = 1'($urandom_range(0, 1));
    case (trk.seq_phase)
      PH_IDLE:
        if (fixed_plan || $urandom_range(0, 3) != 0) start = 1'b1;
      PH_RISE, PH_ECHO: begin
        if (!planned && !fixed_plan) begin
          case ($urandom_range(0, 19))
            0, 1, 2: rise_at = trk.cfg.rise_timeout_us + $urandom_range(0, 3);
            default: rise_at = $urandom_range(0, trk.cfg.rise_timeout_us);
          endcase
          case ($urandom_range(0, 19))
            0, 1:    echo_len = trk.cfg.echo_timeout_us + 2;
            2:       echo_len = $urandom_range(1, 400);
            default: echo_len = $urandom_range(1, 100);
          endcase
        end
        planned = 1'b1;
        if (trk.seq_phase == PH_RISE) echo = (trk.ticks_in_phase >= rise_at);
        else echo = (trk.echo_ticks < echo_len);
        if (noisy && $urandom_range(0, 39) == 0) echo = !echo;
      end
      default: ;
    endcase
    tick_ch.valid <= 1'b1;
    tick_ch.start_request <= start;
    tick_ch.echo_level <= echo;
    do @(posedge clk); while (!tick_ch.ready);
    trk.note_tick(start, echo);
  endtask

  task automatic measure();
    do send_tick(); while (!trk.set_done);
  endtask

  task automatic settle();
    tick_ch.valid <= 1'b0;
    while (trk.due_words.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(logic [2:0] idx, logic wr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] value);
    logic [31:0] rd;
    apb_access(idx, 1'b1, value, rd);
    trk.write_reg(idx, value);
    cfg_writes++;
    if (idx != SPARE_REG) begin
      apb_access(idx, 1'b0, '0, rd);
      if (rd !== trk.reg_value(idx))
        trk.report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                      idx, rd, trk.reg_value(idx)));
    end
  endtask

  task automatic set_all(int unsigned tl, int unsigned th, int unsigned rt,
                         int unsigned et, int unsigned gap, int unsigned avg);
    set_reg(REG_TRIG_LOW, tl);
    set_reg(REG_TRIG_HIGH, th);
    set_reg(REG_RISE_TO, rt);
    set_reg(REG_ECHO_TO, et);
    set_reg(REG_GAP, gap);
    set_reg(REG_AVG_EN, avg);
  endtask

  // result side: checks each word taken, stalls at random
  initial begin
    range_word_t got;
    int unsigned stall_left;
    stall_left = 0;
    word_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && word_ch.valid && word_ch.ready) begin
        got = {word_ch.trigger_level, word_ch.busy_res, word_ch.result_valid,
               word_ch.distance_sixteenths, word_ch.timed_out};
        trk.check_word(got);
      end
      if (long_hold) begin
        long_hold = 1'b0;
        stall_left = 400;
      end else if (stall_left == 0 && take_idle && $urandom_range(0, 5) == 0) begin
        stall_left = gap_len();
      end
      if (stall_left != 0) begin
        stall_left--;
        word_ch.ready <= 1'b0;
      end else begin
        word_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned round;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.start_request <= 1'b0;
    tick_ch.echo_level <= 1'b0;
    fixed_plan = 1'b1;
    noisy = 1'b0;
    send_idle = 1'b1;
    take_idle = 1'b1;
    long_hold = 1'b0;
    cfg_writes = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings, 58 us of echo is one centimeter
    rise_at = 3;
    echo_len = 58;
    measure();

    // zero lengths last one tick, zero timeouts act as one
    settle();
    set_all(0, 0, 0, 0, 0, 0);
    rise_at = 0;
    echo_len = 1;
    measure();
    rise_at = 1;
    measure();

    settle();
    set_all(1, 1, 1, 1, 1, 0);
    rise_at = 0;
    measure();
    rise_at = 1;
    measure();

    // widest settings read back, then long timeouts with a short trigger
    settle();
    set_all(1023, 1023, 65535, 65535, 65535, 0);
    set_reg(REG_TRIG_LOW, 12);
    set_reg(REG_TRIG_HIGH, 9);
    rise_at = 70;
    echo_len = 200;
    measure();

    settle();
    set_reg(SPARE_REG, 32'hFFFF_FFFF);

    // averaging, one-tick gaps
    set_all(3, 2, 20, 100, 0, 1);
    rise_at = 2;
    echo_len = 30;
    measure();

    // echo timeout aborts a set partway
    settle();
    set_reg(REG_GAP, 4);
    echo_len = 40;
    while (!(trk.seq_phase == PH_GAP && trk.readings_taken == 2)) send_tick();
    echo_len = 150;
    measure();

    // averaging switched off mid set: next reading reports alone
    echo_len = 40;
    while (!(trk.seq_phase == PH_GAP && trk.readings_taken == 2)) send_tick();
    settle();
    set_reg(REG_AVG_EN, 0);
    echo_len = 77;
    measure();

    // random settings and echo shapes, with some noise on the echo line
    fixed_plan = 1'b0;
    noisy = 1'b1;
    round = 0;
    while (trk.ticks < ITEM_GOAL) begin
      settle();
      set_all($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(1, 60),
              $urandom_range(1, 150), $urandom_range(0, 10), $urandom_range(0, 1));
      send_idle = ($urandom_range(0, 3) != 0);
      take_idle = ($urandom_range(0, 3) != 0);
      if (round == 0) begin
        // result side holds off while ticks keep coming
        send_idle = 1'b0;
        long_hold = 1'b1;
      end
      repeat ($urandom_range(1, 5)) begin
        if (trk.ticks < ITEM_GOAL) measure();
      end
      round++;
    end

    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d ticks, %0d measurements (%0d timed out, %0d averaged)",
             trk.ticks, trk.sets, trk.timeouts, trk.averaged);
    $display("%0d register writes, %0d output words checked", cfg_writes, trk.words_seen);
    if (trk.errors == 0) begin
      $display("PASS ultrasonic_echo_ranger");
    end else begin
      $display("FAIL ultrasonic_echo_ranger");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout waiting for output words");
    $display("FAIL ultrasonic_echo_ranger");
    $finish;
  end

endmodule
